### rtl/core/sfs_pkg.sv
// ----------------------------------------------------------------------------
// sfs_pkg
// Shared types and constants of the sprite frame sequencer: operation codes,
// configuration register indexes, the mode bundle and the result layout.
// ----------------------------------------------------------------------------
package sfs_pkg;

	// Fixed field widths of the item and result formats.
	localparam int FRAME_W    = 6;
	localparam int WRAP_W     = 16;
	localparam int FT_W       = 7;
	localparam int CFG_ADDR_W = 3;
	localparam int OUT_W      = 32;

	localparam logic [WRAP_W-1:0] WRAP_MAX = '1;

	// Default frame duration after reset: 100 ms with 8 fraction bits.
	localparam int BASE_RESET = 25600;

	typedef enum logic [1:0] {
		OP_TICK    = 2'd0,
		OP_RESTART = 2'd1,
		OP_PLAY    = 2'd2,
		OP_LOAD    = 2'd3
	} op_t;

	// Configuration register indexes.
	localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_TOTAL = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_BASE_DUR    = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_REVERSE     = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] CFG_TABLE       = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] CFG_FLASH       = 3'd4;

	// Mode bits handed from the register bank to the sequencer.
	typedef struct packed {
		logic [FT_W-1:0] frame_total;
		logic            reverse_mode;
		logic            table_mode;
		logic            flash_enable;
	} mode_t;

	// One result; frame_index sits in the lowest bits.
	typedef struct packed {
		logic               stepped;
		logic               flash_dim;
		logic               running;
		logic [WRAP_W-1:0]  wrap_count;
		logic [FRAME_W-1:0] frame_index;
	} res_t;

	localparam int RES_W = $bits(res_t);

endpackage

### rtl/core/sprite_frame_sequencer.sv
// ----------------------------------------------------------------------------
// sprite_frame_sequencer
// Frame timer for sprite animation: ticks accumulate elapsed time, completed
// frame periods step the frame index through the active range.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Handshake          Contents
// s_*      in   s_tvalid/s_tready  s_tuser: opcode; s_tdata: item operands
// m_*      out  m_tvalid/m_tready  m_tdata: frame, wraps, run, flash, stepped
// cfg_*    in   cfg_we             cfg_addr selects register, cfg_data value
//
// One item is taken per clock while s_tready is high. An accepted item waits
// in the input register until the output register is free or being emptied;
// the sequencer processes it then, and its result is loaded into the output
// register at the end of that cycle. The sustained rate is set by the state
// update and the one read port of the duration table. When m_tready is low
// the result holds and one further item is kept in the input register before
// s_tready falls. Reset clears control state and valid flags, not the data
// registers or the duration table, which holds nothing meaningful until written.
//
module sprite_frame_sequencer
	import sfs_pkg::*;
#(
	parameter int MAX_FRAMES = 64,
	parameter int TIME_BITS  = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  s_tvalid,
	output logic                  s_tready,
	// From bit 0: elapsed, frame_a, frame_b, loop_flag, duration, zero fill.
	input  logic [((2*TIME_BITS+2*FRAME_W+1+7)/8)*8-1:0] s_tdata,
	// opcode.
	input  logic [1:0]            s_tuser,

	output logic                  m_tvalid,
	input  logic                  m_tready,
	// From bit 0: frame_index, wrap_count, running, flash_dim, stepped, zero fill.
	output logic [OUT_W-1:0]      m_tdata,

	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [TIME_BITS-1:0]  cfg_data
);

	// Bit positions of the operands inside s_tdata.
	localparam int FA_LO = TIME_BITS;
	localparam int FB_LO = FA_LO + FRAME_W;
	localparam int LF_BIT = FB_LO + FRAME_W;
	localparam int DU_LO = LF_BIT + 1;

	// Configuration registers.
	logic [FT_W-1:0]      frame_total_q;
	logic [TIME_BITS-1:0] base_dur_q;
	logic                 reverse_q;
	logic                 table_q;
	logic                 flash_q;
	logic                 dim_clr;
	mode_t                mode;

	// Input register.
	logic                 valid_s1;
	op_t                  op_s1;
	logic [TIME_BITS-1:0] elapsed_s1;
	logic [FRAME_W-1:0]   fa_s1;
	logic [FRAME_W-1:0]   fb_s1;
	logic                 loop_s1;
	logic [TIME_BITS-1:0] dur_s1;

	// Output register.
	logic                 out_valid_q;
	logic [OUT_W-1:0]     out_data_q;

	logic                 advance;
	logic                 take;
	res_t                 res;

	// The item in the input register is processed when the output register
	// is free or is being emptied in the same cycle.
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign take     = s_tvalid && s_tready;

	// Changing flash_enable restarts the flash phase in the bright state.
	assign dim_clr = cfg_we && (cfg_addr == CFG_FLASH) && (cfg_data[0] != flash_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_total_q <= '0;
			base_dur_q    <= TIME_BITS'(BASE_RESET);
			reverse_q     <= 1'b0;
			table_q       <= 1'b0;
			flash_q       <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_FRAME_TOTAL: frame_total_q <= cfg_data[FT_W-1:0];
				CFG_BASE_DUR:    base_dur_q    <= cfg_data;
				CFG_REVERSE:     reverse_q     <= cfg_data[0];
				CFG_TABLE:       table_q       <= cfg_data[0];
				CFG_FLASH:       flash_q       <= cfg_data[0];
				default:         flash_q       <= flash_q;
			endcase
		end
	end

	always_comb begin
		mode              = '0;
		mode.frame_total  = frame_total_q;
		mode.reverse_mode = reverse_q;
		mode.table_mode   = table_q;
		mode.flash_enable = flash_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Operand registers carry no reset.
	always_ff @(posedge clk) begin
		if (take) begin
			op_s1      <= op_t'(s_tuser);
			elapsed_s1 <= s_tdata[TIME_BITS-1:0];
			fa_s1      <= s_tdata[FA_LO +: FRAME_W];
			fb_s1      <= s_tdata[FB_LO +: FRAME_W];
			loop_s1    <= s_tdata[LF_BIT];
			dur_s1     <= s_tdata[DU_LO +: TIME_BITS];
		end
	end

	sfs_seq #(
		.MAX_FRAMES (MAX_FRAMES),
		.TIME_BITS  (TIME_BITS)
	) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.go            (advance),
		.op            (op_s1),
		.elapsed       (elapsed_s1),
		.frame_a       (fa_s1),
		.frame_b       (fb_s1),
		.loop_flag     (loop_s1),
		.duration      (dur_s1),
		.mode          (mode),
		.base_duration (base_dur_q),
		.dim_clr       (dim_clr),
		.res           (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= OUT_W'(res);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("processed item produced no result");

	a_item_kept: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(op_s1) && $stable(fa_s1))
		else $error("waiting item lost from the input register");

endmodule

### rtl/core/sfs_dur_mem.sv
// ----------------------------------------------------------------------------
// sfs_dur_mem
// Per-frame duration table: one write port, one registered read port. A write
// to the address being read in the same cycle is forwarded to the read data.
// ----------------------------------------------------------------------------
module sfs_dur_mem #(
	parameter int DEPTH  = 64,
	parameter int DATA_W = 24
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DATA_W-1:0]        wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (we && (waddr == raddr)) begin
			rdata_q <= wdata;
		end else begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/core/sfs_seq.sv
// ----------------------------------------------------------------------------
// sfs_seq
// Sequencer state and its update: accumulator, frame index,
// active range, run and loop flags, wrap count and flash phase.
// ----------------------------------------------------------------------------
module sfs_seq
	import sfs_pkg::*;
#(
	parameter int MAX_FRAMES = 64,
	parameter int TIME_BITS  = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 go,
	input  op_t                  op,
	input  logic [TIME_BITS-1:0] elapsed,
	input  logic [FRAME_W-1:0]   frame_a,
	input  logic [FRAME_W-1:0]   frame_b,
	input  logic                 loop_flag,
	input  logic [TIME_BITS-1:0] duration,
	input  mode_t                mode,
	input  logic [TIME_BITS-1:0] base_duration,
	input  logic                 dim_clr,
	output res_t                 res
);

	localparam int FW = $clog2(MAX_FRAMES);
	localparam int AW = TIME_BITS + 2;
	localparam int SW = ($clog2(MAX_FRAMES + 1) > FT_W) ? $clog2(MAX_FRAMES + 1) : FT_W;
	localparam logic signed [FW+1:0] ONE_S = 1;

	logic [AW-1:0]     acc_q, acc_d;
	logic [FW-1:0]     cur_q, cur_d;
	logic [FW-1:0]     ls_q, ls_d;
	logic [FW-1:0]     re_q, re_d;
	logic              rset_q, rset_d;
	logic              loop_q, loop_d;
	logic              run_q, run_d;
	logic [WRAP_W-1:0] wraps_q, wraps_d;
	logic              dim_q, dim_d;
	logic              stepped;

	// Frame operands.
	logic [SW-1:0]        sheet;
	logic [FW-1:0]        last_sheet, cur_last;
	logic                 fa_big, fb_big;
	logic [FW-1:0]        fa_sat, fb_sat, rng_lo, rng_hi;
	logic signed [FW+1:0] cur_ext;

	// Shared move unit.
	logic signed [FW+1:0] mv_target;
	logic [FW-1:0]        mv_ls, mv_last, mv_idx;
	logic                 mv_change, mv_wrap, mv_stop;

	// Accumulator path.
	logic [AW:0]           acc_sum;
	logic [AW-1:0]         acc_sat;
	logic [TIME_BITS-1:0]  period, tab_dur;
	logic                  hit;
	logic                  mem_we;

	assign sheet      = (SW'(mode.frame_total) > SW'(MAX_FRAMES)) ? SW'(MAX_FRAMES)
		: SW'(mode.frame_total);
	assign last_sheet = FW'(sheet - SW'(1));
	assign cur_last   = rset_q ? re_q : last_sheet;
	assign fa_big     = ({26'd0, frame_a} >= 32'(MAX_FRAMES));
	assign fb_big     = ({26'd0, frame_b} >= 32'(MAX_FRAMES));
	assign fa_sat     = fa_big ? FW'(MAX_FRAMES - 1) : FW'(frame_a);
	assign fb_sat     = fb_big ? FW'(MAX_FRAMES - 1) : FW'(frame_b);
	assign rng_lo     = (fa_sat <= fb_sat) ? fa_sat : fb_sat;
	assign rng_hi     = (fa_sat <= fb_sat) ? fb_sat : fa_sat;
	assign cur_ext    = $signed({2'b00, cur_q});

	// Operands of the move unit; a range play already sees its new range.
	always_comb begin
		mv_target = cur_ext;
		mv_ls     = ls_q;
		mv_last   = cur_last;
		unique case (op)
			OP_TICK: begin
				mv_target = mode.reverse_mode ? (cur_ext - ONE_S) : (cur_ext + ONE_S);
			end
			OP_RESTART: begin
				mv_target = $signed({2'b00, fa_sat});
			end
			OP_PLAY: begin
				mv_target = '0;
				mv_ls     = rng_lo;
				mv_last   = rng_hi;
			end
			OP_LOAD: begin
				mv_target = cur_ext;
			end
			default: begin
				mv_target = cur_ext;
			end
		endcase
	end

	always_comb begin
		mv_change = (mode.frame_total != '0) && (mv_target != cur_ext);
		mv_wrap   = 1'b0;
		mv_idx    = mv_target[FW-1:0];
		if (mv_target > $signed({2'b00, mv_last})) begin
			mv_wrap = 1'b1;
			mv_idx  = mv_ls;
		end else if (mv_target < 0) begin
			mv_wrap = 1'b1;
			mv_idx  = mv_last;
		end
		mv_stop = !loop_q && (mv_idx == mv_last);
	end

	assign acc_sum = {1'b0, acc_q} + (AW + 1)'(elapsed);
	assign acc_sat = acc_sum[AW] ? {AW{1'b1}} : acc_sum[AW-1:0];
	assign period  = mode.table_mode ? tab_dur : base_duration;
	assign hit     = (acc_sat >= AW'(period));

	always_comb begin
		acc_d   = acc_q;
		cur_d   = cur_q;
		ls_d    = ls_q;
		re_d    = re_q;
		rset_d  = rset_q;
		loop_d  = loop_q;
		run_d   = run_q;
		wraps_d = wraps_q;
		dim_d   = dim_q;
		stepped = 1'b0;
		mem_we  = 1'b0;
		if (go) begin
			unique case (op)
				OP_TICK: begin
					if (mode.flash_enable || run_q) begin
						acc_d = acc_sat;
						if (hit) begin
							if (run_q && mv_change) begin
								cur_d = mv_idx;
								if (mv_wrap && (wraps_q != WRAP_MAX)) begin
									wraps_d = wraps_q + 1'b1;
								end
								if (mv_stop) begin
									run_d = 1'b0;
								end
							end
							acc_d   = acc_sat - AW'(period);
							dim_d   = mode.flash_enable ? !dim_q : dim_q;
							stepped = 1'b1;
						end
					end
				end
				OP_RESTART: begin
					if (mv_change) begin
						cur_d = mv_idx;
					end
					run_d   = 1'b1;
					wraps_d = '0;
				end
				OP_PLAY: begin
					ls_d   = rng_lo;
					re_d   = rng_hi;
					rset_d = 1'b1;
					if (mv_change) begin
						cur_d = mv_idx;
						if (mv_wrap && (wraps_q != WRAP_MAX)) begin
							wraps_d = wraps_q + 1'b1;
						end
					end
					loop_d = loop_flag;
					acc_d  = '0;
					run_d  = 1'b1;
				end
				OP_LOAD: begin
					mem_we = !fa_big;
				end
				default: begin
					mem_we = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			cur_q   <= '0;
			ls_q    <= '0;
			re_q    <= '0;
			rset_q  <= 1'b0;
			loop_q  <= 1'b1;
			run_q   <= 1'b1;
			wraps_q <= '0;
			dim_q   <= 1'b0;
		end else begin
			acc_q   <= acc_d;
			cur_q   <= cur_d;
			ls_q    <= ls_d;
			re_q    <= re_d;
			rset_q  <= rset_d;
			loop_q  <= loop_d;
			run_q   <= run_d;
			wraps_q <= wraps_d;
			dim_q   <= dim_clr ? 1'b0 : dim_d;
		end
	end

	// The table is read at the frame that will be current after this cycle,
	// so the entry for the next item is ready in the read register.
	sfs_dur_mem #(
		.DEPTH  (MAX_FRAMES),
		.DATA_W (TIME_BITS)
	) u_dur_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (FW'(frame_a)),
		.wdata (duration),
		.raddr (cur_d),
		.rdata (tab_dur)
	);

	always_comb begin
		res             = '0;
		res.frame_index = FRAME_W'(cur_d);
		res.wrap_count  = wraps_d;
		res.running     = run_d;
		res.flash_dim   = dim_d;
		res.stepped     = stepped;
	end

	a_frame_in_sheet: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cur_q) < MAX_FRAMES)
		else $error("frame index left the table range");

	a_frozen_tick: assert property (@(posedge clk) disable iff (!arst_n)
		go && (op == OP_TICK) && !run_q && !mode.flash_enable
		|=> $stable(acc_q) && $stable(cur_q) && $stable(wraps_q))
		else $error("stopped sequencer changed on a tick");

	a_wraps_grow: assert property (@(posedge clk) disable iff (!arst_n)
		go && (op != OP_RESTART) |=> wraps_q >= $past(wraps_q))
		else $error("wrap count fell without a restart");

endmodule
